@@ hw/rtl/bcrg_pkg.sv @@
// shared types and constants for the beat clock, reset and run gate unit
`timescale 1ns / 1ps

package bcrg_pkg;

  localparam int BEAT_FRAC_BITS = 16;
  localparam int BEAT_W = 48;
  localparam int TIME_W = 32;
  localparam int PW_W = 20;
  localparam int BPB_W = 5;

  localparam int DIVIDEND_W = 32;
  localparam int DIVISOR_W = 8;
  localparam int DIV_CNT_W = $clog2(DIVIDEND_W);

  localparam logic [PW_W-1:0] PULSE_WIDTH_RESET = PW_W'(10000);
  localparam logic [BPB_W-1:0] BEATS_PER_BAR_RESET = BPB_W'(4);

  // blink phase: now_ms/100 is (now_ms>>2)/25, now_ms/250 is (now_ms>>1)/125,
  // each done as a multiply by a rounded-up reciprocal, exact over the whole range
  localparam logic [TIME_W-1:0] LED_FAST_RECIP = 32'd1374389535;
  localparam logic [TIME_W-1:0] LED_SLOW_RECIP = 32'd2199023256;
  localparam int LED_FAST_QBIT = 35;
  localparam int LED_SLOW_QBIT = 38;

  localparam int IN_DATA_W = 120;
  localparam int OUT_DATA_W = 8;
  localparam int ADDR_W = 3;

  localparam logic REG_PULSE_WIDTH = 1'b0;
  localparam logic REG_BEATS_PER_BAR = 1'b1;

  typedef struct packed {
    logic start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic busy;
    logic [DIVISOR_W-1:0] rem;
  } div_rsp_t;

endpackage

@@ hw/rtl/bcrg_div.sv @@
// restoring divider, one quotient bit per cycle, gives the remainder
`timescale 1ns / 1ps

module bcrg_div import bcrg_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                  busy;
  logic                  done;
  logic [DIV_CNT_W-1:0]  cnt;
  logic [DIVIDEND_W-1:0] shreg;
  logic [DIVISOR_W-1:0]  divisor;
  logic [DIVISOR_W-1:0]  rem;

  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  ge;

  assign trial = {rem, shreg[DIVIDEND_W-1]};
  assign ge = trial >= {1'b0, divisor};
  assign diff = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      shreg <= req.dividend;
      divisor <= req.divisor;
      rem <= '0;
      cnt <= DIV_CNT_W'(DIVIDEND_W - 1);
    end else if (busy) begin
      shreg <= {shreg[DIVIDEND_W-2:0], 1'b0};
      rem <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      cnt <= cnt - 1'b1;
    end
  end

  assign rsp.done = done;
  assign rsp.busy = busy;
  assign rsp.rem = rem;

endmodule

@@ hw/rtl/beat_clock_reset_run_gate_unit.sv @@
// beat clock, reset pulse, run gate and status led sequencer around a restoring divider
// a request runs through S_EVAL then S_FIN; when a beat rise runs the bar check it waits in S_BAR
//   for the divider (32 quotient bits plus its done strobe) before S_FIN
// a new request is taken only in S_IDLE, after the last result is loaded for output; an output stall holds S_FIN
// reset: synchronous, active high; clears enable, edge history, pulses and run gate,
//   and loads pulse width 10000 us and 4 beats per bar
`timescale 1ns / 1ps

module beat_clock_reset_run_gate_unit import bcrg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // now_us[31:0], now_ms[63:32], beat_pos[111:64], playing[112], reset_in_level[113],
  // enable_button[114], wifi_up[115], peers_present[116], zero fill[119:117]
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // clock_out[0], reset_out[1], run_out[2], enabled[3], status_led[4], zero fill[7:5]
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EVAL = 4'b0010,
    S_BAR  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t state;

  // configuration
  logic [PW_W-1:0]  pulse_len;
  logic [BPB_W-1:0] beats_per_bar;

  // latched request
  logic [TIME_W-1:0]        now_us;
  logic [TIME_W-1:0]        now_ms;
  logic signed [BEAT_W-1:0] beat_pos;
  logic playing, reset_in_level, enable_button, wifi_up, peers_present;

  // tracking state
  logic sync_enabled, button_prev, reset_in_prev, playing_prev, beat_valid, run_gate;
  logic [TIME_W-1:0] last_whole_beat;
  logic clock_busy, reset_busy;
  logic [TIME_W-1:0] clock_end_time, reset_end_time;

  // evaluation results
  logic en_n, bv_n, pp_n, rg_n, fire_r, fire_c;
  logic signed [TIME_W-1:0] wb;
  logic [TIME_W-1:0] wb_abs;
  logic [TIME_W-1:0] pulse_end;
  logic [DIVISOR_W-1:0] bar_div;
  logic [TIME_W-1:0] led_x;
  logic [TIME_W-1:0] led_m;
  logic [2*TIME_W-1:0] led_prod;
  logic led_phase;
  logic [TIME_W-1:0] ck_diff, rs_diff;
  logic ck_busy_fin, rs_busy_fin, led_fin;

  div_req_t div_req;
  div_rsp_t div_rsp;

  bcrg_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign s_tready = state == S_IDLE;
  assign pready = 1'b1;

  // config port
  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_len <= PULSE_WIDTH_RESET;
      beats_per_bar <= BEATS_PER_BAR_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_PULSE_WIDTH:   pulse_len <= pwdata[PW_W-1:0];
        REG_BEATS_PER_BAR: beats_per_bar <= pwdata[BPB_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_PULSE_WIDTH:   prdata = 32'(pulse_len);
      REG_BEATS_PER_BAR: prdata = 32'(beats_per_bar);
      default:           prdata = '0;
    endcase
  end

  // floor of the fixed-point position
  assign wb = TIME_W'(beat_pos >>> BEAT_FRAC_BITS);
  assign wb_abs = wb[TIME_W-1] ? (~wb + 1'b1) : wb;
  assign pulse_end = now_us + TIME_W'(pulse_len);
  assign bar_div = (beats_per_bar == '0) ? DIVISOR_W'(1) : DIVISOR_W'(beats_per_bar);

  always_comb begin
    en_n = sync_enabled;
    bv_n = beat_valid;
    pp_n = playing_prev;
    rg_n = run_gate;
    fire_r = 1'b0;
    fire_c = 1'b0;
    if (enable_button && !button_prev) begin
      en_n = !en_n;
      bv_n = 1'b0;
      pp_n = 1'b0;
      if (!en_n) rg_n = 1'b0;
    end
    if (reset_in_level && !reset_in_prev) begin
      fire_r = 1'b1;
      bv_n = 1'b0;
    end
    if (en_n) begin
      if (playing != pp_n) begin
        if (playing) begin
          fire_r = 1'b1;
          rg_n = 1'b1;
          bv_n = 1'b0;
        end else begin
          rg_n = 1'b0;
        end
        pp_n = playing;
      end
      if (playing) begin
        if (!bv_n) begin
          bv_n = 1'b1;
        end else if (wb > $signed(last_whole_beat)) begin
          fire_c = 1'b1;
        end
      end
    end
  end

  // blink phase is bit 0 of now_ms divided by the blink period
  assign led_x = !wifi_up ? {2'b00, now_ms[TIME_W-1:2]} : {1'b0, now_ms[TIME_W-1:1]};
  assign led_m = !wifi_up ? LED_FAST_RECIP : LED_SLOW_RECIP;
  assign led_prod = (2*TIME_W)'(led_x) * (2*TIME_W)'(led_m);
  assign led_phase = !wifi_up ? led_prod[LED_FAST_QBIT] : led_prod[LED_SLOW_QBIT];

  // bar position check on the magnitude of the new beat
  always_comb begin
    div_req.start = (state == S_EVAL) && fire_c;
    div_req.dividend = wb_abs;
    div_req.divisor = bar_div;
  end

  // pulse expiry with wrapping time
  assign ck_diff = now_us - clock_end_time;
  assign rs_diff = now_us - reset_end_time;
  assign ck_busy_fin = clock_busy && ck_diff[TIME_W-1];
  assign rs_busy_fin = reset_busy && rs_diff[TIME_W-1];
  assign led_fin = !sync_enabled ? 1'b0 : ((!wifi_up || !peers_present) ? led_phase : 1'b1);

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      now_us <= s_tdata[31:0];
      now_ms <= s_tdata[63:32];
      beat_pos <= s_tdata[111:64];
      playing <= s_tdata[112];
      reset_in_level <= s_tdata[113];
      enable_button <= s_tdata[114];
      wifi_up <= s_tdata[115];
      peers_present <= s_tdata[116];
    end
    if (state == S_EVAL) begin
      if (en_n && playing) last_whole_beat <= wb;
      if (fire_c) clock_end_time <= pulse_end;
      if (fire_r) reset_end_time <= pulse_end;
    end
    if (state == S_BAR && div_rsp.done && div_rsp.rem == '0) reset_end_time <= pulse_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sync_enabled <= 1'b0;
      button_prev <= 1'b0;
      reset_in_prev <= 1'b0;
      playing_prev <= 1'b0;
      beat_valid <= 1'b0;
      run_gate <= 1'b0;
      clock_busy <= 1'b0;
      reset_busy <= 1'b0;
      m_tvalid <= 1'b0;
      m_tdata <= '0;
    end else begin
      if (m_tvalid && m_tready && state != S_FIN) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) state <= S_EVAL;
        end
        S_EVAL: begin
          sync_enabled <= en_n;
          button_prev <= enable_button;
          reset_in_prev <= reset_in_level;
          playing_prev <= pp_n;
          beat_valid <= bv_n;
          run_gate <= rg_n;
          if (fire_c) clock_busy <= 1'b1;
          if (fire_r) reset_busy <= 1'b1;
          if (fire_c) state <= S_BAR;
          else state <= S_FIN;
        end
        S_BAR: begin
          if (div_rsp.done) begin
            // bar boundary when the beat divides evenly
            if (div_rsp.rem == '0) reset_busy <= 1'b1;
            state <= S_FIN;
          end
        end
        S_FIN: begin
          clock_busy <= ck_busy_fin;
          reset_busy <= rs_busy_fin;
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata <= {3'b000, led_fin, sync_enabled, run_gate, rs_busy_fin, ck_busy_fin};
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_gate_needs_enable: assert property (@(posedge clk) disable iff (rst)
    run_gate |-> sync_enabled)
    else $error("run gate high while sync disabled");

  a_accept_to_eval: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> state == S_EVAL)
    else $error("accepted request not evaluated next cycle");

  a_div_done_owner: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == S_BAR)
    else $error("divider finished with no waiting phase");

  a_idle_div_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !div_rsp.busy)
    else $error("divider busy while idle");
`endif

endmodule

@@ bench/tb_top.sv @@
// self-checking bench for the beat clock, reset pulse and run gate unit
`timescale 1ns / 1ps

module tb_top;
  import bcrg_pkg::*;

  // poll tick as packed on s_tdata, lowest field last
  typedef struct packed {
    logic [2:0]        pad;
    logic              peers_present;
    logic              wifi_up;
    logic              enable_button;
    logic              reset_in_level;
    logic              playing;
    logic signed [47:0] beat_pos;
    logic [31:0]       now_ms;
    logic [31:0]       now_us;
  } tick_t;

  // gate outputs as packed on m_tdata
  typedef struct packed {
    logic [2:0] pad;
    logic       status_led;
    logic       enabled;
    logic       run_out;
    logic       reset_out;
    logic       clock_out;
  } gates_t;

  localparam logic signed [47:0] ONE_BEAT = 48'sh1_0000;
  localparam int PHASES = 8;
  localparam int PHASE_TICKS = 250;
  localparam int TAIL_CYCLES = 100;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [ADDR_W-1:0]     paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  beat_clock_reset_run_gate_unit dut (
    .clk(clk), .rst(rst),
    .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  tick_t  pending_ticks[$];
  gates_t expected_gates[$];
  int     failures = 0;
  int     ticks_sent = 0;
  int     results_checked = 0;
  int     settings_used = 1;
  bit     idle_on = 1'b1;
  int     src_gap = 0;
  int     sink_stall = 0;
  gates_t want, got;

  // predictor copy of the block
  logic [PW_W-1:0]  pulse_width_cfg = PULSE_WIDTH_RESET;
  logic [BPB_W-1:0] beats_per_bar_cfg = BEATS_PER_BAR_RESET;
  logic             sync_on = 1'b0;
  logic             button_was = 1'b0;
  logic             reset_in_was = 1'b0;
  logic             playing_was = 1'b0;
  logic             beat_tracked = 1'b0;
  logic [31:0]      last_beat = '0;
  logic             gate_high = 1'b0;
  logic             clk_pulse_on = 1'b0;
  logic [31:0]      clk_pulse_end = '0;
  logic             reset_active = 1'b0;
  logic [31:0]      rst_pulse_end = '0;

  // stimulus generator state
  logic [31:0]       gen_us = '0;
  logic [31:0]       gen_ms = '0;
  logic signed [47:0] gen_pos = '0;
  logic gen_play = 1'b0, gen_rin = 1'b0, gen_btn = 1'b0, gen_wifi = 1'b1, gen_peers = 1'b1;

  function automatic gates_t predict_gates(input tick_t t);
    gates_t           o;
    logic signed [47:0] shifted;
    logic [31:0]      beat;
    logic [31:0]      lag;
    int               bar_len;
    int               bar_pos;
    o = '0;
    if (t.enable_button && !button_was) begin
      sync_on = !sync_on;
      beat_tracked = 1'b0;
      playing_was = 1'b0;
      if (!sync_on) gate_high = 1'b0;
    end
    button_was = t.enable_button;
    if (t.reset_in_level && !reset_in_was) begin
      rst_pulse_end = t.now_us + {12'b0, pulse_width_cfg};
      reset_active = 1'b1;
      beat_tracked = 1'b0;
    end
    reset_in_was = t.reset_in_level;
    if (sync_on) begin
      if (t.playing != playing_was) begin
        if (t.playing) begin
          rst_pulse_end = t.now_us + {12'b0, pulse_width_cfg};
          reset_active = 1'b1;
          gate_high = 1'b1;
          beat_tracked = 1'b0;
        end else begin
          gate_high = 1'b0;
        end
        playing_was = t.playing;
      end
      if (t.playing) begin
        shifted = t.beat_pos >>> BEAT_FRAC_BITS;
        beat = shifted[31:0];
        if (!beat_tracked) begin
          beat_tracked = 1'b1;
        end else if ($signed(beat) > $signed(last_beat)) begin
          clk_pulse_end = t.now_us + {12'b0, pulse_width_cfg};
          clk_pulse_on = 1'b1;
          // zero beats per bar counts as one
          bar_len = (beats_per_bar_cfg == '0) ? 1 : int'(beats_per_bar_cfg);
          bar_pos = $signed(beat) % bar_len;
          if (bar_pos < 0) bar_pos += bar_len;
          if (bar_pos == 0) begin
            rst_pulse_end = t.now_us + {12'b0, pulse_width_cfg};
            reset_active = 1'b1;
          end
        end
        last_beat = beat;
      end
    end
    // expiry against wrapping time
    lag = t.now_us - clk_pulse_end;
    if (clk_pulse_on && !lag[31]) clk_pulse_on = 1'b0;
    lag = t.now_us - rst_pulse_end;
    if (reset_active && !lag[31]) reset_active = 1'b0;
    if (!sync_on) o.status_led = 1'b0;
    else if (!t.wifi_up) o.status_led = (t.now_ms / 32'd100) % 2 == 1;
    else if (!t.peers_present) o.status_led = (t.now_ms / 32'd250) % 2 == 1;
    else o.status_led = 1'b1;
    o.clock_out = clk_pulse_on;
    o.reset_out = reset_active;
    o.run_out = gate_high;
    o.enabled = sync_on;
    return o;
  endfunction

  task automatic check_field(input string name, input logic exp_v, input logic act_v);
    if (exp_v !== act_v) begin
      $error("%s expected %0d got %0d", name, exp_v, act_v);
      failures++;
    end
  endtask

  // source side: one request held until accepted, random gap bursts between
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      src_gap <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_gates.push_back(predict_gates(s_tdata));
        ticks_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (src_gap > 0) begin
          src_gap <= src_gap - 1;
          s_tvalid <= 1'b0;
        end else if (pending_ticks.size() > 0 && idle_on && $urandom_range(0, 7) == 0) begin
          src_gap <= $urandom_range(0, 15);
          s_tvalid <= 1'b0;
        end else if (pending_ticks.size() > 0) begin
          s_tdata <= pending_ticks.pop_front();
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // sink side: compare each result with the oldest prediction, random stalls
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      sink_stall <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_gates.size() == 0) begin
          $error("result %h arrived with nothing expected", m_tdata);
          failures++;
        end else begin
          want = expected_gates.pop_front();
          got = m_tdata;
          check_field("clock_out", want.clock_out, got.clock_out);
          check_field("reset_out", want.reset_out, got.reset_out);
          check_field("run_out", want.run_out, got.run_out);
          check_field("enabled", want.enabled, got.enabled);
          check_field("status_led", want.status_led, got.status_led);
          results_checked++;
        end
      end
      if (sink_stall > 0) begin
        sink_stall <= sink_stall - 1;
        m_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        sink_stall <= $urandom_range(0, 15);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  function automatic tick_t mk_tick(input logic [31:0] us, input logic [31:0] ms,
                                    input logic signed [47:0] pos, input logic play,
                                    input logic rin, input logic btn, input logic wifi,
                                    input logic peers);
    tick_t t;
    t = '0;
    t.now_us = us;
    t.now_ms = ms;
    t.beat_pos = pos;
    t.playing = play;
    t.reset_in_level = rin;
    t.enable_button = btn;
    t.wifi_up = wifi;
    t.peers_present = peers;
    return t;
  endfunction

  task automatic write_reg(input logic idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 2'b00});
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_PULSE_WIDTH) pulse_width_cfg = value[PW_W-1:0];
    else beats_per_bar_cfg = value[BPB_W-1:0];
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (!(pending_ticks.size() == 0 && !s_tvalid && expected_gates.size() == 0))
      @(negedge clk);
  endtask

  // mostly a coherent session: time and beat move forward, levels change now and then
  task automatic queue_session(input int count);
    tick_t       t;
    int          roll;
    logic [63:0] r64;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        r64 = {$urandom, $urandom};
        t = '0;
        t.now_us = $urandom;
        t.now_ms = $urandom;
        t.beat_pos = r64[47:0];
        t.playing = 1'($urandom_range(0, 1));
        t.reset_in_level = 1'($urandom_range(0, 1));
        t.enable_button = 1'($urandom_range(0, 1));
        t.wifi_up = 1'($urandom_range(0, 1));
        t.peers_present = 1'($urandom_range(0, 1));
      end else begin
        gen_us += $urandom_range(200, 3000);
        if (roll == 8) gen_us = 32'hFFFF_FFFF - $urandom_range(0, 20000);
        gen_ms += $urandom_range(0, 4);
        roll = $urandom_range(0, 99);
        if (roll < 80) gen_pos += 48'($urandom_range(0, 40000));
        else if (roll < 88) gen_pos -= 48'($urandom_range(0, 32'h0010_0000));
        else if (roll < 98) gen_pos += 48'($urandom_range(0, 32'h0004_0000));
        else begin
          r64 = {$urandom, $urandom};
          gen_pos = r64[47:0];
        end
        if ($urandom_range(0, 39) == 0) gen_btn = !gen_btn;
        if ($urandom_range(0, 29) == 0) gen_rin = !gen_rin;
        if ($urandom_range(0, 29) == 0) gen_play = !gen_play;
        if ($urandom_range(0, 29) == 0) gen_wifi = !gen_wifi;
        if ($urandom_range(0, 29) == 0) gen_peers = !gen_peers;
        t = mk_tick(gen_us, gen_ms, gen_pos, gen_play, gen_rin, gen_btn, gen_wifi, gen_peers);
      end
      pending_ticks.push_back(t);
    end
  endtask

  initial begin
    logic [PW_W-1:0]  pw_plan [PHASES];
    logic [BPB_W-1:0] bpb_plan [PHASES];
    pw_plan = '{20'd10000, 20'd0, 20'd1, 20'hFFFFF, 20'd2500, 20'd700, 20'd5000, 20'd10000};
    bpb_plan = '{5'd4, 5'd0, 5'd1, 5'd16, 5'd31, 5'd3, 5'd7, 5'd4};
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed ticks on the reset settings
    pending_ticks.push_back(mk_tick(0, 0, 0, 0, 0, 0, 0, 0));
    // reset input while disabled
    pending_ticks.push_back(mk_tick(100, 0, 0, 0, 1, 0, 0, 0));
    pending_ticks.push_back(mk_tick(200, 150, 0, 0, 0, 1, 0, 0));
    // transport start, first beat only recorded
    pending_ticks.push_back(mk_tick(300, 300, 0, 1, 0, 0, 1, 0));
    pending_ticks.push_back(mk_tick(1300, 0, ONE_BEAT, 1, 0, 0, 1, 1));
    pending_ticks.push_back(mk_tick(2300, 0, 48'sh1_8000, 1, 0, 0, 1, 1));
    pending_ticks.push_back(mk_tick(3300, 0, 48'sh4_0000, 1, 0, 0, 1, 1));
    pending_ticks.push_back(mk_tick(13300, 0, 48'sh4_0000, 1, 0, 0, 1, 1));
    // negative beats and a negative bar boundary
    pending_ticks.push_back(mk_tick(14000, 0, -48'sh5_8000, 1, 0, 0, 1, 1));
    pending_ticks.push_back(mk_tick(15000, 0, -48'sh4_0000, 1, 0, 0, 1, 1));
    pending_ticks.push_back(mk_tick(16000, 0, -48'sh3_4000, 1, 0, 0, 1, 1));
    pending_ticks.push_back(mk_tick(17000, 0, 48'sh7FFF_FFFF_FFFF, 1, 0, 0, 1, 1));
    pending_ticks.push_back(mk_tick(18000, 0, 48'sh8000_0000_0000, 1, 0, 0, 1, 1));
    // pulse end time wraps past zero
    pending_ticks.push_back(mk_tick(32'hFFFF_F000, 0, 48'sh8000_0001_0000, 1, 0, 0, 1, 1));
    pending_ticks.push_back(mk_tick(32'h0000_0010, 0, 48'sh8000_0001_0000, 1, 0, 0, 1, 1));
    pending_ticks.push_back(mk_tick(32'h0000_2000, 0, 48'sh8000_0001_0000, 1, 0, 0, 1, 1));
    // reset input while enabled drops the beat sync
    pending_ticks.push_back(mk_tick(32'h0000_3000, 0, 48'sh8000_0002_0000, 1, 1, 0, 1, 1));
    pending_ticks.push_back(mk_tick(32'h0000_4000, 0, 48'sh8000_0003_0000, 1, 0, 0, 1, 1));
    pending_ticks.push_back(mk_tick(32'h0000_5000, 0, 48'sh8000_0004_0000, 0, 0, 0, 1, 1));
    pending_ticks.push_back(mk_tick(32'h0000_6000, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 1));
    // disable, then beats are ignored
    pending_ticks.push_back(mk_tick(32'h0000_7000, 32'hFFFF_FFFF, 0, 0, 0, 1, 1, 1));
    pending_ticks.push_back(mk_tick(32'h0000_8000, 0, ONE_BEAT, 1, 0, 0, 1, 1));
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      write_reg(REG_PULSE_WIDTH, 32'(pw_plan[p]));
      write_reg(REG_BEATS_PER_BAR, 32'(bpb_plan[p]));
      settings_used++;
      idle_on = (p != PHASES - 1) && (p % 3 != 2);
      queue_session(PHASE_TICKS);
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_gates.size() != 0) begin
      $error("%0d results never arrived", expected_gates.size());
      failures++;
    end
    $display("drove %0d poll ticks over %0d register settings", ticks_sent, settings_used);
    $display("checked %0d results, %0d mismatches", results_checked, failures);
    if (failures == 0) begin
      $display("PASS beat_clock_reset_run_gate_unit");
    end else begin
      $display("FAIL beat_clock_reset_run_gate_unit");
    end
    $finish;
  end

  initial begin
    #15_000_000;
    $display("FAIL beat_clock_reset_run_gate_unit");
    $finish;
  end

endmodule
